// ===== sv/krt_pkg.sv =====
// Package for the keyed record table: command and result beat types,
// stored record layout, opcode, status and sequencer state codes.
// No dependencies.
package krt_pkg;

  localparam int KeyW       = 240;
  localparam int MaxResults = 16;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_LIST   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_LIST_RD,
    S_LIST_EMIT,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_e;

  typedef struct packed {
    logic        [2:0]  opcode;
    logic        [63:0] key_bytes_0_7;
    logic        [63:0] key_bytes_8_15;
    logic        [63:0] key_bytes_16_23;
    logic        [47:0] key_bytes_24_29;
    logic signed [15:0] score_one;
    logic signed [15:0] score_two;
    logic signed [15:0] score_three;
  } cmd_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [3:0]  position;
    logic        [63:0] out_bytes_0_7;
    logic        [63:0] out_bytes_8_15;
    logic        [63:0] out_bytes_16_23;
    logic        [47:0] out_bytes_24_29;
    logic signed [15:0] out_score_one;
    logic signed [15:0] out_score_two;
    logic signed [15:0] out_score_three;
    logic        [4:0]  entries_now;
    logic               final_item;
  } res_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [15:0]     s3;
    logic [15:0]     s2;
    logic [15:0]     s1;
  } rec_t;

  // Clear every key byte that follows the first zero byte.
  function automatic logic [KeyW-1:0] norm_key(input logic [KeyW-1:0] k);
    logic [29:0]     zb;
    logic [KeyW-1:0] r;
    zb = '0;
    r  = k;
    for (int i = 0; i < 30; i++) begin
      zb[i] = (k[8*i +: 8] == 8'h00);
    end
    for (int i = 1; i < 30; i++) begin
      if ((zb & ((30'd1 << i) - 30'd1)) != 30'd0) begin
        r[8*i +: 8] = 8'h00;
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/keyed_record_table.sv =====
// Keyed record table top level: record memory, scan/shift sequencer and
// registered result beat. Depends on krt_pkg.
//
// A command beat is taken when start_i is high and busy_o is low; busy_o then
// stays high until the command is finished. Results leave as one-cycle beats
// on res_o marked by done_o, in the cycle after they are formed, and cannot be
// held off. All record reads go through the single registered read port of
// the record memory, so each record visited passes through a read state
// (S_SCAN_RD, S_LIST_RD or S_SHIFT_RD) before the state that uses its data.
// Insert needs no read; search, update and delete scan until the match, delete
// then moves each later record down one place, and list reports at most 16
// records. Opcodes 5 to 7 give no result.
module keyed_record_table
  import krt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic busy_o,
  output logic done_o,
  output res_t res_o
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(TABLE_DEPTH + 1);
  localparam logic [FW-1:0] DepthC = FW'(TABLE_DEPTH);

  state_e        state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] idx_q, idx_d;
  logic [FW-1:0] idx_inc;
  logic          done_q, done_d;
  res_t          res_q, res_d;
  logic [2:0]    op_q;
  rec_t          cmd_q;
  rec_t          rd_q;
  rec_t          mem_q [TABLE_DEPTH];

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  rec_t          mem_wdata;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          list_last;

  assign idx_inc   = idx_q + 1'b1;
  assign list_last = (idx_inc == fill_q) || (int'(idx_q) == MaxResults - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == S_IDLE && start_i) begin
      op_q      <= cmd_i.opcode;
      cmd_q.key <= norm_key({cmd_i.key_bytes_24_29, cmd_i.key_bytes_16_23,
                             cmd_i.key_bytes_8_15, cmd_i.key_bytes_0_7});
      cmd_q.s1  <= cmd_i.score_one;
      cmd_q.s2  <= cmd_i.score_two;
      cmd_q.s3  <= cmd_i.score_three;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    res_d     = '0;
    mem_we    = 1'b0;
    mem_waddr = idx_q[IW-1:0];
    mem_wdata = cmd_q;
    rd_en     = 1'b0;
    rd_addr   = idx_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (start_i) begin
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_d = S_IDLE;
        case (op_q)
          OP_INSERT: begin
            done_d           = 1'b1;
            res_d.final_item = 1'b1;
            res_d.entries_now = 5'(fill_q);
            if (fill_q >= DepthC) begin
              res_d.status = ST_FULL;
            end else begin
              mem_we                = 1'b1;
              mem_waddr             = fill_q[IW-1:0];
              fill_d                = fill_q + 1'b1;
              res_d.status          = ST_OK;
              res_d.position        = 4'(fill_q);
              res_d.out_bytes_0_7   = cmd_q.key[63:0];
              res_d.out_bytes_8_15  = cmd_q.key[127:64];
              res_d.out_bytes_16_23 = cmd_q.key[191:128];
              res_d.out_bytes_24_29 = cmd_q.key[239:192];
              res_d.out_score_one   = cmd_q.s1;
              res_d.out_score_two   = cmd_q.s2;
              res_d.out_score_three = cmd_q.s3;
              res_d.entries_now     = 5'(fill_q + 1'b1);
            end
          end
          OP_DELETE, OP_UPDATE, OP_SEARCH, OP_LIST: begin
            if (fill_q == '0) begin
              done_d           = 1'b1;
              res_d.status     = ST_EMPTY;
              res_d.final_item = 1'b1;
            end else if (op_q == OP_LIST) begin
              state_d = S_LIST_RD;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_SCAN_RD: begin
        rd_en   = 1'b1;
        state_d = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (rd_q.key == cmd_q.key) begin
          done_d                = 1'b1;
          state_d               = S_IDLE;
          res_d.status          = ST_OK;
          res_d.position        = 4'(idx_q);
          res_d.out_bytes_0_7   = rd_q.key[63:0];
          res_d.out_bytes_8_15  = rd_q.key[127:64];
          res_d.out_bytes_16_23 = rd_q.key[191:128];
          res_d.out_bytes_24_29 = rd_q.key[239:192];
          res_d.out_score_one   = rd_q.s1;
          res_d.out_score_two   = rd_q.s2;
          res_d.out_score_three = rd_q.s3;
          res_d.entries_now     = 5'(fill_q);
          res_d.final_item      = 1'b1;
          if (op_q == OP_UPDATE) begin
            mem_we                = 1'b1;
            mem_wdata.key         = rd_q.key;
            res_d.out_score_one   = cmd_q.s1;
            res_d.out_score_two   = cmd_q.s2;
            res_d.out_score_three = cmd_q.s3;
          end else if (op_q == OP_DELETE) begin
            fill_d            = fill_q - 1'b1;
            res_d.entries_now = 5'(fill_q - 1'b1);
            if (idx_inc < fill_q) begin
              state_d = S_SHIFT_RD;
            end
          end
        end else if (idx_inc == fill_q) begin
          done_d            = 1'b1;
          state_d           = S_IDLE;
          res_d.status      = ST_NOT_FOUND;
          res_d.entries_now = 5'(fill_q);
          res_d.final_item  = 1'b1;
        end else begin
          idx_d   = idx_inc;
          state_d = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_inc[IW-1:0];
        state_d = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_q;
        idx_d     = idx_inc;
        state_d   = (idx_inc < fill_q) ? S_SHIFT_RD : S_IDLE;
      end

      S_LIST_RD: begin
        rd_en   = 1'b1;
        state_d = S_LIST_EMIT;
      end

      S_LIST_EMIT: begin
        done_d                = 1'b1;
        res_d.status          = ST_OK;
        res_d.position        = 4'(idx_q);
        res_d.out_bytes_0_7   = rd_q.key[63:0];
        res_d.out_bytes_8_15  = rd_q.key[127:64];
        res_d.out_bytes_16_23 = rd_q.key[191:128];
        res_d.out_bytes_24_29 = rd_q.key[239:192];
        res_d.out_score_one   = rd_q.s1;
        res_d.out_score_two   = rd_q.s2;
        res_d.out_score_three = rd_q.s3;
        res_d.entries_now     = 5'(fill_q);
        res_d.final_item      = list_last;
        if (list_last) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_inc;
          state_d = S_LIST_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result beat without a command in flight");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthC)
    else $error("record count above table depth");

  a_start_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted command did not raise busy");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_RD || state_q == S_LIST_RD) |-> idx_q < fill_q)
    else $error("record read beyond the filled region");

endmodule

// ===== bench/keyed_record_table_checker.sv =====
// Checker for the keyed record table: watches the command and result beats,
// keeps its own copy of the records, predicts every result beat and compares.
// Depends on krt_pkg.
`timescale 1ns / 1ps
module keyed_record_table_checker
  import krt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  input  logic busy_i,
  input  logic done_i,
  input  res_t res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   cmd_count_o,
  output int   beat_count_o,
  output int   full_count_o,
  output int   empty_count_o,
  output int   miss_count_o
);

  logic [KeyW-1:0]    rec_key   [TABLE_DEPTH];
  logic signed [15:0] rec_s1    [TABLE_DEPTH];
  logic signed [15:0] rec_s2    [TABLE_DEPTH];
  logic signed [15:0] rec_s3    [TABLE_DEPTH];
  int                 rec_fill;
  res_t               awaited_rows[$];

  // Clear every byte after the first zero byte.
  function automatic logic [KeyW-1:0] clean_key(input logic [KeyW-1:0] raw);
    logic [KeyW-1:0] k;
    bit              ended;
    k     = raw;
    ended = 1'b0;
    for (int b = 0; b < 30; b++) begin
      if (ended) begin
        k[8*b +: 8] = 8'h00;
      end else if (raw[8*b +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return k;
  endfunction

  function automatic res_t row_beat(input status_e st, input int pos,
                                    input logic [KeyW-1:0] k,
                                    input logic signed [15:0] s1,
                                    input logic signed [15:0] s2,
                                    input logic signed [15:0] s3,
                                    input logic last);
    res_t r;
    r.status          = st;
    r.position        = pos[3:0];
    r.out_bytes_0_7   = k[63:0];
    r.out_bytes_8_15  = k[127:64];
    r.out_bytes_16_23 = k[191:128];
    r.out_bytes_24_29 = k[239:192];
    r.out_score_one   = s1;
    r.out_score_two   = s2;
    r.out_score_three = s3;
    r.entries_now     = rec_fill[4:0];
    r.final_item      = last;
    return r;
  endfunction

  task automatic push_status(input status_e st);
    awaited_rows.push_back(row_beat(st, 0, '0, '0, '0, '0, 1'b1));
  endtask

  task automatic push_record(input int pos, input logic last);
    awaited_rows.push_back(row_beat(ST_OK, pos, rec_key[pos], rec_s1[pos],
                                    rec_s2[pos], rec_s3[pos], last));
  endtask

  task automatic apply_command(input cmd_t c);
    logic [KeyW-1:0]    k;
    logic signed [15:0] g1, g2, g3;
    logic [KeyW-1:0]    gk;
    int                 hit;
    int                 n;
    k = clean_key({c.key_bytes_24_29, c.key_bytes_16_23, c.key_bytes_8_15,
                   c.key_bytes_0_7});
    hit = -1;
    if (c.opcode == OP_INSERT) begin
      cmd_count_o++;
      if (rec_fill >= TABLE_DEPTH) begin
        full_count_o++;
        push_status(ST_FULL);
      end else begin
        rec_key[rec_fill] = k;
        rec_s1[rec_fill]  = c.score_one;
        rec_s2[rec_fill]  = c.score_two;
        rec_s3[rec_fill]  = c.score_three;
        rec_fill++;
        push_record(rec_fill - 1, 1'b1);
      end
      return;
    end
    if (c.opcode > OP_LIST) return;
    cmd_count_o++;
    if (rec_fill == 0) begin
      empty_count_o++;
      push_status(ST_EMPTY);
      return;
    end
    if (c.opcode == OP_LIST) begin
      n = (rec_fill > MaxResults) ? MaxResults : rec_fill;
      for (int i = 0; i < n; i++) push_record(i, i == n - 1);
      return;
    end
    for (int i = 0; i < rec_fill; i++) begin
      if (hit < 0 && rec_key[i] == k) hit = i;
    end
    if (hit < 0) begin
      miss_count_o++;
      push_status(ST_NOT_FOUND);
    end else if (c.opcode == OP_DELETE) begin
      gk = rec_key[hit];
      g1 = rec_s1[hit];
      g2 = rec_s2[hit];
      g3 = rec_s3[hit];
      for (int i = hit; i + 1 < rec_fill; i++) begin
        rec_key[i] = rec_key[i+1];
        rec_s1[i]  = rec_s1[i+1];
        rec_s2[i]  = rec_s2[i+1];
        rec_s3[i]  = rec_s3[i+1];
      end
      rec_fill--;
      awaited_rows.push_back(row_beat(ST_OK, hit, gk, g1, g2, g3, 1'b1));
    end else begin
      if (c.opcode == OP_UPDATE) begin
        rec_s1[hit] = c.score_one;
        rec_s2[hit] = c.score_two;
        rec_s3[hit] = c.score_three;
      end
      push_record(hit, 1'b1);
    end
  endtask

  task automatic note_diff(input string what, input logic [63:0] want,
                           input logic [63:0] got, inout bit bad);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      bad = 1'b1;
    end
  endtask

  task automatic check_beat(input res_t got);
    res_t want;
    bit   bad;
    bad = 1'b0;
    beat_count_o++;
    if (awaited_rows.size() == 0) begin
      $display("%0t: result beat with none expected, expected nothing actual %h",
               $time, got);
      fail_count_o++;
      return;
    end
    want = awaited_rows.pop_front();
    note_diff("status", 64'(want.status), 64'(got.status), bad);
    note_diff("position", 64'(want.position), 64'(got.position), bad);
    note_diff("out_bytes_0_7", want.out_bytes_0_7, got.out_bytes_0_7, bad);
    note_diff("out_bytes_8_15", want.out_bytes_8_15, got.out_bytes_8_15, bad);
    note_diff("out_bytes_16_23", want.out_bytes_16_23, got.out_bytes_16_23, bad);
    note_diff("out_bytes_24_29", 64'(want.out_bytes_24_29), 64'(got.out_bytes_24_29),
              bad);
    note_diff("out_score_one", 64'(want.out_score_one), 64'(got.out_score_one), bad);
    note_diff("out_score_two", 64'(want.out_score_two), 64'(got.out_score_two), bad);
    note_diff("out_score_three", 64'(want.out_score_three), 64'(got.out_score_three),
              bad);
    note_diff("entries_now", 64'(want.entries_now), 64'(got.entries_now), bad);
    note_diff("final_item", 64'(want.final_item), 64'(got.final_item), bad);
    if (bad) fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rec_fill      = 0;
      fail_count_o  = 0;
      cmd_count_o   = 0;
      beat_count_o  = 0;
      full_count_o  = 0;
      empty_count_o = 0;
      miss_count_o  = 0;
      awaited_rows.delete();
    end else begin
      if (done_i === 1'b1) check_beat(res_i);
      if (start_i && busy_i === 1'b0) apply_command(cmd_i);
    end
    pending_o = awaited_rows.size();
  end

endmodule

// ===== bench/keyed_record_table_tb.sv =====
// Testbench top for the keyed record table: clock, reset, directed and
// random command beats in bursts, watchdog and verdict.
// Depends on krt_pkg, keyed_record_table and keyed_record_table_checker.
`timescale 1ns / 1ps
module keyed_record_table_tb;
  import krt_pkg::*;

  localparam int         Depth      = 16;
  localparam int         RandItems  = 450;
  localparam int         IdleLimit  = 1000;
  localparam int         PoolSize   = 8;
  localparam logic [2:0] OpRsvdLo   = 3'd5;
  localparam logic [2:0] OpRsvdHi   = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  cmd_t cmd_i;
  logic busy_o;
  logic done_o;
  res_t res_o;

  int fail_count, pending, cmd_count, beat_count;
  int full_count, empty_count, miss_count;
  int idle_cycles;

  logic [KeyW-1:0] name_pool[PoolSize];
  int              name_len [PoolSize];

  keyed_record_table #(.TABLE_DEPTH(Depth)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  keyed_record_table_checker #(.TABLE_DEPTH(Depth)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .busy_i       (busy_o),
    .done_i       (done_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .cmd_count_o  (cmd_count),
    .beat_count_o (beat_count),
    .full_count_o (full_count),
    .empty_count_o(empty_count),
    .miss_count_o (miss_count)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, no beat for %0d cycles", $time, IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic cmd_t pack_cmd(input logic [2:0] op, input logic [KeyW-1:0] k,
                                    input logic [15:0] s1, input logic [15:0] s2,
                                    input logic [15:0] s3);
    cmd_t c;
    c.opcode          = op;
    c.key_bytes_0_7   = k[63:0];
    c.key_bytes_8_15  = k[127:64];
    c.key_bytes_16_23 = k[191:128];
    c.key_bytes_24_29 = k[239:192];
    c.score_one       = s1;
    c.score_two       = s2;
    c.score_three     = s3;
    return c;
  endfunction

  // Fill every byte past the terminator at byte len with random junk.
  function automatic logic [KeyW-1:0] with_tail(input logic [KeyW-1:0] k, input int len);
    logic [KeyW-1:0] r;
    r = k;
    for (int b = len + 1; b < 30; b++) r[8*b +: 8] = 8'($urandom_range(255, 0));
    return r;
  endfunction

  function automatic logic [KeyW-1:0] any_key();
    logic [KeyW-1:0] k;
    for (int b = 0; b < 30; b++) k[8*b +: 8] = 8'($urandom_range(255, 0));
    return k;
  endfunction

  function automatic logic [15:0] any_score();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    return 16'($urandom_range(16'hffff, 0));
  endfunction

  function automatic cmd_t random_cmd(input int mode);
    int         r;
    int         idx;
    logic [2:0] op;
    logic [KeyW-1:0] k;
    r = $urandom_range(99, 0);
    case (mode)
      0:       op = (r < 55) ? OP_INSERT : (r < 65) ? OP_DELETE : (r < 75) ? OP_UPDATE :
                    (r < 88) ? OP_SEARCH : OP_LIST;
      1:       op = (r < 30) ? OP_INSERT : (r < 50) ? OP_DELETE : (r < 65) ? OP_UPDATE :
                    (r < 85) ? OP_SEARCH : OP_LIST;
      default: op = (r < 15) ? OP_INSERT : (r < 60) ? OP_DELETE : (r < 70) ? OP_UPDATE :
                    (r < 85) ? OP_SEARCH : OP_LIST;
    endcase
    if ($urandom_range(99, 0) < 85) begin
      idx = $urandom_range(PoolSize - 1, 0);
      k   = name_pool[idx];
      if ($urandom_range(1, 0) == 1) k = with_tail(k, name_len[idx]);
    end else begin
      k = any_key();
    end
    return pack_cmd(op, k, any_score(), any_score(), any_score());
  endfunction

  task automatic issue(input cmd_t c);
    @(negedge clk_i);
    start_i <= 1'b1;
    cmd_i   <= c;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
  endtask

  task automatic rest(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  initial begin
    logic [KeyW-1:0] ab_key;
    logic [KeyW-1:0] ff_key;
    logic [KeyW-1:0] xyz_key;
    int              counted;
    int              burst_left;
    int              mode;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cmd_i       = '0;

    for (int p = 0; p < PoolSize; p++) begin
      name_len[p]  = (p == 0) ? 30 : (p == 1) ? 0 : $urandom_range(29, 1);
      name_pool[p] = '0;
      for (int b = 0; b < name_len[p]; b++) begin
        name_pool[p][8*b +: 8] = 8'($urandom_range(255, 1));
      end
    end
    ab_key        = '0;
    ab_key[15:0]  = 16'h4241;
    xyz_key       = '0;
    xyz_key[23:0] = 24'h5a5958;
    ff_key        = '1;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table
    issue(pack_cmd(OP_SEARCH, ab_key, 16'd0, 16'd0, 16'd0));
    issue(pack_cmd(OP_DELETE, ab_key, 16'd0, 16'd0, 16'd0));
    rest(3);
    issue(pack_cmd(OP_UPDATE, ab_key, 16'd1, 16'd1, 16'd1));
    issue(pack_cmd(OP_LIST, '0, 16'd0, 16'd0, 16'd0));
    // extremes, empty name, terminated names with junk, duplicates
    issue(pack_cmd(OP_INSERT, ff_key, 16'h7fff, 16'h8000, 16'hffff));
    issue(pack_cmd(OP_INSERT, '0, 16'h8000, 16'h7fff, 16'h0000));
    issue(pack_cmd(OP_INSERT, with_tail(ab_key, 2), 16'd1, 16'd2, 16'd3));
    rest(1);
    issue(pack_cmd(OP_INSERT, with_tail(ab_key, 2), 16'd4, 16'd5, 16'd6));
    issue(pack_cmd(OP_SEARCH, with_tail(ab_key, 2), 16'd0, 16'd0, 16'd0));
    issue(pack_cmd(OP_UPDATE, ab_key, 16'h8000, 16'h7fff, 16'h0001));
    issue(pack_cmd(OP_SEARCH, with_tail('0, 0), 16'd0, 16'd0, 16'd0));
    issue(pack_cmd(OP_SEARCH, xyz_key, 16'd0, 16'd0, 16'd0));
    rest(5);
    issue(pack_cmd(OP_UPDATE, with_tail(xyz_key, 3), 16'd9, 16'd9, 16'd9));
    issue(pack_cmd(OP_DELETE, xyz_key, 16'd0, 16'd0, 16'd0));
    issue(pack_cmd(OP_LIST, any_key(), 16'hffff, 16'hffff, 16'hffff));
    issue(pack_cmd(OP_DELETE, with_tail(ab_key, 2), 16'd0, 16'd0, 16'd0));
    issue(pack_cmd(OP_LIST, '0, 16'd0, 16'd0, 16'd0));
    for (int o = int'(OpRsvdLo); o <= int'(OpRsvdHi); o++) begin
      issue(pack_cmd(o[2:0], ff_key, 16'hffff, 16'hffff, 16'hffff));
    end
    issue(pack_cmd(OP_DELETE, ff_key, 16'd0, 16'd0, 16'd0));
    issue(pack_cmd(OP_DELETE, ab_key, 16'd0, 16'd0, 16'd0));
    issue(pack_cmd(OP_LIST, '0, 16'd0, 16'd0, 16'd0));
    issue(pack_cmd(OP_DELETE, '0, 16'd0, 16'd0, 16'd0));
    issue(pack_cmd(OP_LIST, '0, 16'd0, 16'd0, 16'd0));

    // random bursts; grow, mix and drain phases push the table to full and empty
    counted    = 0;
    burst_left = 0;
    while (counted < RandItems) begin
      if (burst_left == 0) begin
        if ($urandom_range(9, 0) < 7) begin
          rest(($urandom_range(9, 0) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 1));
        end
        burst_left = $urandom_range(20, 1);
      end
      burst_left--;
      mode = (counted / 60) % 3;
      if ($urandom_range(99, 0) < 3) begin
        issue(pack_cmd(3'($urandom_range(OpRsvdHi, OpRsvdLo)), any_key(), any_score(),
                       any_score(), any_score()));
      end else begin
        issue(random_cmd(mode));
        counted++;
      end
    end
    rest(1);

    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("covered %0d commands and %0d result beats", cmd_count, beat_count);
    $display("full table %0d times, empty table %0d times, no match %0d times",
             full_count, empty_count, miss_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== keyed_record_table.f =====
sv/krt_pkg.sv
sv/keyed_record_table.sv
bench/keyed_record_table_checker.sv
bench/keyed_record_table_tb.sv
